// ===== rtl/gclm_pkg.sv =====
// gclm_pkg: shared constants for the grey convert / line mirror block.
// Holds the luma weights, the average reciprocal, item kinds and register indexes.
// No dependencies.
package gclm_pkg;

    // Q16 luma weights, sum is 65536
    localparam logic [15:0] LUMA_R = 16'd13933;
    localparam logic [15:0] LUMA_G = 16'd46871;
    localparam logic [15:0] LUMA_B = 16'd4732;

    // floor(s/3) == (s * 683) >> 11 for s <= 765
    localparam logic [9:0] AVG_RECIP = 10'd683;
    localparam int         AVG_SHIFT = 11;

    localparam logic [11:0] LINE_WIDTH_RESET = 12'd640;

    typedef enum logic
    {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        CFG_LINE_WIDTH = 2'd0,
        CFG_GREY_MODE  = 2'd1
    } cfg_index_t;

    typedef enum logic
    {
        MODE_LUMA    = 1'b0,
        MODE_AVERAGE = 1'b1
    } grey_mode_t;

endpackage

// ===== rtl/grey_convert_line_mirror_unit.sv =====
// grey_convert_line_mirror_unit: RGB to grey conversion with a horizontal line mirror.
// Depends on gclm_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per accepted edge. kind 0 is a pixel
//   (red, green, blue), kind 1 is a drain tick that only pushes out a pending pixel.
//   Output channel (out_valid / out_stall): grey value of the mirrored pixel and
//   line_end on the last pixel (original first pixel) of each mirrored line.
//   An item emits at most one result, taken from the previously completed line.
// Timing:
//   One item per cycle, sustained while the receiver does not stall. A result passes
//   the registered line store read and then the output register before it is visible.
// Stall:
//   in_stall rises only while a result sits in the output register and the receiver
//   stalls; the whole two-stage pipe then holds, with its write repeated harmlessly.
// Reset:
//   Counters, bank select and pending flag clear; line_width goes to 640, grey_mode to
//   luma. The line store is not cleared: it is only read after it has been written.
// Config (cfg_we / cfg_index / cfg_data): write only while the block is idle.
module grey_convert_line_mirror_unit
    import gclm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  grey,
    output logic        line_end
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    // configuration registers
    logic [11:0] line_width_reg;
    logic        grey_mode_reg;

    // line control state
    logic          fill_bank_reg, fill_bank_next;
    logic [CW-1:0] fill_count_reg, fill_count_next;
    logic [CW-1:0] drain_count_reg, drain_count_next;
    logic          pending_reg, pending_next;

    // stage 1: pixel waiting for its store write, read in flight
    logic          s1_wr_valid_reg;
    logic [AW-1:0] s1_wr_addr_reg;
    logic [7:0]    s1_red_reg, s1_green_reg, s1_blue_reg;
    logic          s1_mode_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic          s1_fwd_reg;
    logic [7:0]    s1_fwd_data_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] grey_reg;
    logic       line_end_reg;

    logic [7:0] line_store [DEPTH];
    logic [7:0] rd_data_reg;

    logic          advance;
    logic          accept;
    logic          is_pixel;
    logic [CW-1:0] wm1;
    logic          drain_last;
    logic [CW-1:0] drain_idx;
    logic [CW-1:0] fill_pos;
    logic          fill_done;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          emit;
    logic [23:0]   luma_sum;
    logic [9:0]    chan_sum;
    logic [19:0]   avg_prod;
    logic [7:0]    s1_grey;

    // pipe moves unless a result is held by the receiver
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;
    assign is_pixel = (kind == KIND_PIXEL);

    // effective width minus one: zero acts as one, clamp at MAX_WIDTH
    always_comb
    begin
        if (line_width_reg == 12'd0)
        begin
            wm1 = '0;
        end
        else if (32'(line_width_reg) > MAX_WIDTH)
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(line_width_reg - 12'd1);
        end
    end

    // mirrored read: last pixel first, index 0 ends the line
    assign drain_last = (drain_count_reg >= wm1);
    assign drain_idx  = drain_last ? '0 : (wm1 - drain_count_reg);
    assign rd_addr    = fill_bank_reg ? AW'(drain_idx)
                                      : AW'(MAX_WIDTH) + AW'(drain_idx);

    // fill position pins at the last slot if the width shrank mid-line
    assign fill_done = (fill_count_reg >= wm1);
    assign fill_pos  = fill_done ? wm1 : fill_count_reg;
    assign wr_addr   = fill_bank_reg ? AW'(MAX_WIDTH) + AW'(fill_pos) : AW'(fill_pos);

    assign emit = accept && pending_reg;

    always_comb
    begin
        fill_bank_next   = fill_bank_reg;
        fill_count_next  = fill_count_reg;
        drain_count_next = drain_count_reg;
        pending_next     = pending_reg;
        if (emit)
        begin
            if (drain_last)
            begin
                pending_next     = 1'b0;
                drain_count_next = '0;
            end
            else
            begin
                drain_count_next = drain_count_reg + CW'(1);
            end
        end
        if (accept && is_pixel)
        begin
            if (fill_done)
            begin
                fill_count_next  = '0;
                fill_bank_next   = !fill_bank_reg;
                pending_next     = 1'b1;
                drain_count_next = '0;
            end
            else
            begin
                fill_count_next = fill_count_reg + CW'(1);
            end
        end
    end

    // grey conversion of the stage 1 pixel
    assign luma_sum = 24'(LUMA_R * s1_red_reg) + 24'(LUMA_G * s1_green_reg)
                    + 24'(LUMA_B * s1_blue_reg);
    assign chan_sum = 10'(s1_red_reg) + 10'(s1_green_reg) + 10'(s1_blue_reg);
    assign avg_prod = 20'(chan_sum * AVG_RECIP);
    assign s1_grey  = (s1_mode_reg == MODE_AVERAGE) ? avg_prod[AVG_SHIFT +: 8]
                                                    : luma_sum[23:16];

    // line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (s1_wr_valid_reg)
        begin
            line_store[s1_wr_addr_reg] <= s1_grey;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_data_reg <= line_store[rd_addr];
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            grey_mode_reg  <= MODE_LUMA;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_WIDTH: line_width_reg <= cfg_data;
                CFG_GREY_MODE:  grey_mode_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // control state and stage 1 / output valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_bank_reg   <= 1'b0;
            fill_count_reg  <= '0;
            drain_count_reg <= '0;
            pending_reg     <= 1'b0;
            s1_wr_valid_reg <= 1'b0;
            s1_emit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fill_bank_reg   <= fill_bank_next;
            fill_count_reg  <= fill_count_next;
            drain_count_reg <= drain_count_next;
            pending_reg     <= pending_next;
            if (advance)
            begin
                s1_wr_valid_reg <= accept && is_pixel;
                s1_emit_reg     <= emit;
                out_valid_reg   <= s1_emit_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_wr_addr_reg  <= wr_addr;
            s1_red_reg      <= red;
            s1_green_reg    <= green;
            s1_blue_reg     <= blue;
            s1_mode_reg     <= grey_mode_reg;
            s1_last_reg     <= drain_last;
            // the pixel just ahead writes the slot being read this cycle
            s1_fwd_reg      <= s1_wr_valid_reg && (s1_wr_addr_reg == rd_addr);
            s1_fwd_data_reg <= s1_grey;
            grey_reg        <= s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg;
            line_end_reg    <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign grey      = grey_reg;
    assign line_end  = line_end_reg;

endmodule

// ===== rtl/gclm_checker.sv =====
// gclm_checker: port-level checks for grey_convert_line_mirror_unit, bound to the top.
// Depends on gclm_pkg and on the top level's port names.
module gclm_checker
    import gclm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       kind,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] grey,
    input logic       line_end
);

    logic drain_seen;
    assign drain_seen = in_valid && (kind == KIND_DRAIN);

    // input only stalls when a result is held at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a held result");

    // a new result traces back to an accepted item through stage 1 and the output register
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching item");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && !drain_seen) |=> ($stable(grey) && $stable(line_end)))
        else $error("stalled result changed");

endmodule

bind grey_convert_line_mirror_unit gclm_checker u_gclm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .grey      (grey),
    .line_end  (line_end)
);

// ===== tb/tb_grey_convert_line_mirror_unit.sv =====
`timescale 1ns / 100ps
// Testbench for grey_convert_line_mirror_unit: drives RGB pixel and drain items, predicts
// the mirrored grey stream with its own line-store model and checks every result in order.
// Depends on gclm_pkg and the grey_convert_line_mirror_unit RTL.

module tb_grey_convert_line_mirror_unit;
    import gclm_pkg::*;

    localparam int MAX_W         = 2048;
    localparam int SETTLE_CYCLES = 6;      // pipe is two deep, leave some margin
    localparam int HOLD_CYCLES   = 250;    // long receiver hold-off
    localparam int FINAL_LIMIT   = 50000;
    localparam int N_PHASES      = 12;

    // register slots past the end of the map, writes there must be ignored
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    typedef struct
    {
        kind_t      op;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_item_t;

    typedef struct
    {
        logic [7:0] grey;
        logic       line_end;
    } mirror_px_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [11:0] cfg_data  = 12'd0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        kind      = KIND_PIXEL;
    logic [7:0]  red       = 8'd0;
    logic [7:0]  green     = 8'd0;
    logic [7:0]  blue      = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  grey;
    logic        line_end;

    grey_convert_line_mirror_unit #(.MAX_WIDTH(MAX_W)) u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .grey      (grey),
        .line_end  (line_end)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Line mirror model state (own copy of the registers too)
    // ------------------------------------------------------------------
    logic [7:0]  line_mem [0:2*MAX_W-1];
    logic        fill_sel  = 1'b0;
    int unsigned fill_cnt  = 0;
    int unsigned drain_cnt = 0;
    logic        line_busy = 1'b0;     // a completed line is waiting to be mirrored
    logic [11:0] rw_width  = LINE_WIDTH_RESET;
    grey_mode_t  rw_mode   = MODE_LUMA;

    rgb_item_t   rgb_feed_q[$];        // items waiting for the driver
    mirror_px_t  mirror_exp_q[$];      // mirrored pixels still owed by the DUT
    rgb_item_t   on_port;
    mirror_px_t  seen_want;

    int src_idle_pct = 26;
    int snk_idle_pct = 49;
    int n_accepted   = 0;
    int hold_at      = 32'h7fff_ffff;
    int hold_left    = 0;
    logic hold_done  = 1'b0;

    int n_err     = 0;
    int n_pixels  = 0;
    int n_drains  = 0;
    int n_results = 0;
    int n_writes  = 0;
    int n_in_held = 0;

    function automatic int unsigned clamp_width(input logic [11:0] v);
        if (v == 12'd0)
            return 1;
        if (v > MAX_W)
            return MAX_W;
        return v;
    endfunction

    function automatic logic [7:0] grey_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        int unsigned s;
        if (rw_mode == MODE_AVERAGE)
            s = (int'(r) + int'(g) + int'(b)) / 3;
        else
            s = (int'(LUMA_R) * int'(r) + int'(LUMA_G) * int'(g) + int'(LUMA_B) * int'(b)) >> 16;
        return s[7:0];
    endfunction

    // One accepted item: pop a mirrored pixel out of the idle bank first,
    // then write the new grey value into the fill bank.
    task automatic predict_mirror(input rgb_item_t it);
        int unsigned w;
        int unsigned idx;
        int unsigned pos;
        logic        last;
        mirror_px_t  px;
        w = clamp_width(rw_width);
        if (line_busy)
        begin
            last = (drain_cnt >= w - 1);
            idx  = last ? 0 : w - 1 - drain_cnt;
            px.grey     = line_mem[(fill_sel ? 0 : MAX_W) + idx];
            px.line_end = last;
            mirror_exp_q.push_back(px);
            if (last)
            begin
                line_busy = 1'b0;
                drain_cnt = 0;
            end
            else
                drain_cnt++;
        end
        if (it.op == KIND_PIXEL)
        begin
            pos = (fill_cnt < w) ? fill_cnt : w - 1;
            line_mem[(fill_sel ? MAX_W : 0) + pos] = grey_of(it.r, it.g, it.b);
            if (fill_cnt >= w - 1)
            begin
                fill_cnt  = 0;
                fill_sel  = ~fill_sel;
                line_busy = 1'b1;
                drain_cnt = 0;
            end
            else
                fill_cnt++;
        end
    endtask

    function automatic void note_error(input string msg);
        n_err++;
        if (n_err <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued items, predicts on each accepted one
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_mirror(on_port);
                n_accepted <= n_accepted + 1;
                if (on_port.op == KIND_PIXEL)
                    n_pixels++;
                else
                    n_drains++;
            end
            if (in_valid && in_stall)
                n_in_held++;
            // a stalled item stays put; otherwise decide on the next one
            if (!in_valid || !in_stall)
            begin
                if (rgb_feed_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    on_port = rgb_feed_q.pop_front();
                    in_valid <= 1'b1;
                    kind     <= on_port.op;
                    red      <= on_port.r;
                    green    <= on_port.g;
                    blue     <= on_port.b;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed once by the stimulus via hold_at
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && n_accepted >= hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks accepted results against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (mirror_exp_q.size() == 0)
                    note_error($sformatf("unexpected result grey=%0d line_end=%0b",
                                         grey, line_end));
                else
                begin
                    seen_want = mirror_exp_q.pop_front();
                    if (grey !== seen_want.grey || line_end !== seen_want.line_end)
                        note_error($sformatf("grey exp %0d got %0d, line_end exp %0b got %0b",
                                             seen_want.grey, grey, seen_want.line_end,
                                             line_end));
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_chan();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 12)
            return 8'h00;
        if (p < 24)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        rgb_item_t it;
        it.op = KIND_PIXEL;
        it.r  = r;
        it.g  = g;
        it.b  = b;
        rgb_feed_q.push_back(it);
    endtask

    // channels carry junk on a drain, the block must ignore them
    task automatic push_drain();
        rgb_item_t it;
        it.op = KIND_DRAIN;
        it.r  = pick_chan();
        it.g  = pick_chan();
        it.b  = pick_chan();
        rgb_feed_q.push_back(it);
    endtask

    // sender pauses until everything queued is taken and every result is back
    task automatic wait_drained();
        while (rgb_feed_q.size() != 0 || in_valid || mirror_exp_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_writes++;
        case (idx)
            CFG_LINE_WIDTH: rw_width = val;
            CFG_GREY_MODE:  rw_mode  = grey_mode_t'(val[0]);
            default:        ;
        endcase
        @(negedge clk);
    endtask

    // A wider line must not start reading a pending line beyond what was written
    // into its bank, so flush the pending line before growing the width.
    task automatic set_width(input logic [11:0] val);
        int unsigned w_cur;
        int unsigned left;
        w_cur = clamp_width(rw_width);
        if (clamp_width(val) > w_cur && line_busy)
        begin
            left = (drain_cnt >= w_cur - 1) ? 1 : w_cur - drain_cnt;
            repeat (left) push_drain();
            wait_drained();
        end
        write_reg(CFG_LINE_WIDTH, val);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned ph;
        int unsigned n;
        int unsigned tail;
        int unsigned w_eff;
        int          cnt;
        logic [11:0] w_val;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset width, drain with nothing pending, channel extremes
        push_drain();
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd0, 8'd0);
        wait_drained();

        // shrink to the fill count mid-line: next pixel closes the line
        set_width(12'd3);
        push_pixel(8'd0, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd255);
        push_drain();
        push_drain();
        push_drain();
        wait_drained();

        // average mode (upper data bits set), unused slots, one-pixel lines
        write_reg(CFG_GREY_MODE, 12'hFFF);
        write_reg(CFG_SPARE_2, 12'h555);
        write_reg(CFG_SPARE_3, 12'hAAA);
        set_width(12'd1);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd1, 8'd2, 8'd3);
        push_pixel(8'd254, 8'd255, 8'd255);
        push_drain();
        push_drain();
        wait_drained();

        // back to luma, width zero behaves as one
        write_reg(CFG_GREY_MODE, 12'hFFE);
        set_width(12'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd255);
        push_drain();
        push_drain();
        wait_drained();

        // random phases: idle profile A, then swapped, then none
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < 4)
            begin
                src_idle_pct = 26;
                snk_idle_pct = 49;
            end
            else if (ph < 8)
            begin
                src_idle_pct = 49;
                snk_idle_pct = 26;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            case (ph)
                3:
                begin
                    w_val = 12'd1;
                    n     = $urandom_range(60, 90);
                end
                5:
                begin
                    w_val = 12'd200;        // one long line, mirrored while the next fills
                    n     = 240;
                end
                7:
                begin
                    w_val = 12'($urandom_range(60, 120));
                    n     = $urandom_range(100, 180);
                end
                9:
                begin
                    w_val = 12'd4095;       // clamps to the widest line, partial fill
                    n     = 60;
                end
                10:
                begin
                    w_val = 12'($urandom_range(4, 16));
                    n     = 80;             // enough lines to back up behind the hold-off
                end
                default:
                begin
                    w_val = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(2, 24));
                    n     = $urandom_range(40, 60);
                end
            endcase

            write_reg(CFG_GREY_MODE, 12'($urandom_range(0, 4095)));
            set_width(w_val);
            w_eff = clamp_width(w_val);

            // receiver holds off long while the sender keeps streaming
            if (ph == 10)
                hold_at = n_accepted + 20;

            for (int unsigned i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 8)
                    push_drain();
                else
                    push_pixel(pick_chan(), pick_chan(), pick_chan());
            end
            // sometimes flush the tail of the line with a burst of drains
            if ($urandom_range(0, 1) == 1)
            begin
                tail = (w_eff > 30) ? 32 : w_eff + 2;
                repeat ($urandom_range(1, tail)) push_drain();
            end
            wait_drained();
        end

        cnt = 0;
        while ((rgb_feed_q.size() != 0 || in_valid || mirror_exp_q.size() != 0)
               && cnt < FINAL_LIMIT)
        begin
            @(negedge clk);
            cnt++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mirror_exp_q.size() != 0)
            note_error($sformatf("%0d mirrored pixels never arrived", mirror_exp_q.size()));

        $display("run: %0d pixels, %0d drains, %0d mirrored results, %0d register writes",
                 n_pixels, n_drains, n_results, n_writes);
        $display("run: widths 0 to 4095 incl. 1 and 2048, both grey modes, %0d input stall cycles",
                 n_in_held);
        if (n_err == 0)
            $display("** grey_convert_line_mirror_unit: PASSED **");
        else
            $display("** grey_convert_line_mirror_unit: FAILED **");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("watchdog expired with %0d results outstanding", mirror_exp_q.size());
        $display("** grey_convert_line_mirror_unit: FAILED **");
        $finish;
    end

endmodule
